@@ hw/rtl/vsl_pkg.sv @@
// ----------------------------------------------------------------------------
// vsl_pkg
// Shared types and constants of the velocity slew limiter.
// ----------------------------------------------------------------------------
package vsl_pkg;

    // input opcodes
    localparam logic [1:0] OP_CMD  = 2'd0;
    localparam logic [1:0] OP_ODOM = 2'd1;
    localparam logic [1:0] OP_CFB  = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    // feedback modes
    localparam logic [1:0] FB_NONE = 2'd0;
    localparam logic [1:0] FB_ODOM = 2'd1;
    localparam logic [1:0] FB_CMD  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_SMOOTHER_ON   = 3'd0;
    localparam logic [2:0] REG_FEEDBACK_MODE = 3'd1;
    localparam logic [2:0] REG_SPEED_LIMITS  = 3'd2;
    localparam logic [2:0] REG_ACCEL_STEPS   = 3'd3;
    localparam logic [2:0] REG_DECEL_STEPS   = 3'd4;

    // timing constants in microseconds
    localparam logic [31:0] DEFAULT_INTERVAL = 32'd100000;
    localparam logic [34:0] TIMEOUT_CAP      = 35'd500000;

    // kind of a queued request
    typedef enum logic [1:0] {
        K_CMD,
        K_FB,
        K_TICK
    } kind_t;

    // back end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FB,
        S_PREP,
        S_MUL1,
        S_MUL2,
        S_CMP,
        S_DIV,
        S_APPLY,
        S_MED,
        S_OUT
    } state_t;

    typedef struct packed {
        logic        smoother_on;
        logic [1:0]  feedback_mode;
        logic [59:0] speed_limits;
        logic [47:0] accel_steps;
        logic [47:0] decel_steps;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // mode three behaves as no feedback
    function automatic logic [1:0] fb_eff(input logic [1:0] mode);
        return (mode == 2'd3) ? FB_NONE : mode;
    endfunction

endpackage

@@ hw/rtl/vsl_front.sv @@
// ----------------------------------------------------------------------------
// vsl_front
// Accepts input requests, saturates and clamps velocities, drops feedback of
// the wrong kind and pushes the rest into the request queue.
// ----------------------------------------------------------------------------
module vsl_front #(
    parameter int VEL_WIDTH = 32
) (
    input  vsl_pkg::cfg_t                    cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [127:0]                     s_tdata,  // time_us, vel_x, vel_y, vel_w
    input  logic [1:0]                       s_tuser,  // opcode
    input  vsl_pkg::q_stat_t                 q_stat,
    output logic                             push,
    output logic [2+32+3*VEL_WIDTH-1:0]      push_data
);
    import vsl_pkg::*;

    localparam int XW = ((VEL_WIDTH > 32) ? VEL_WIDTH : 32) + 1;
    localparam logic signed [XW-1:0] VMAX =
        {{(XW-VEL_WIDTH+1){1'b0}}, {(VEL_WIDTH-1){1'b1}}};
    localparam logic signed [XW-1:0] VMIN = ~VMAX;

    function automatic logic signed [XW-1:0] sat_x(input logic signed [XW-1:0] v);
        return (v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v);
    endfunction

    kind_t                       kind;
    logic                        keep;
    logic signed [VEL_WIDTH-1:0] vel [3];

    // saturate, clamp commands against the speed limits
    always_comb
    begin
        logic signed [XW-1:0] v;
        logic signed [XW-1:0] lim;
        for (int i = 0; i < 3; i++)
        begin
            v   = sat_x(XW'($signed(s_tdata[32+32*i +: 32])));
            lim = XW'({1'b0, cfg.speed_limits[20*i +: 20]});
            if (s_tuser == OP_CMD)
            begin
                if (v > 0)
                    v = (v < lim) ? v : lim;
                else
                    v = (v > -lim) ? v : -lim;
                v = sat_x(v);
            end
            vel[i] = VEL_WIDTH'(v);
        end
    end

    // classify
    always_comb
    begin
        unique case (s_tuser)
            OP_CMD:  begin kind = K_CMD;  keep = 1'b1; end
            OP_ODOM: begin kind = K_FB;   keep = (fb_eff(cfg.feedback_mode) == FB_ODOM); end
            OP_CFB:  begin kind = K_FB;   keep = (fb_eff(cfg.feedback_mode) == FB_CMD); end
            default: begin kind = K_TICK; keep = 1'b1; end
        endcase
    end

    assign s_tready  = !q_stat.full;
    assign push      = s_tvalid && s_tready && keep;
    assign push_data = {vel[2], vel[1], vel[0], s_tdata[31:0], kind};

endmodule

@@ hw/rtl/vsl_queue.sv @@
// ----------------------------------------------------------------------------
// vsl_queue
// Two-entry request queue between the front and back ends.
// ----------------------------------------------------------------------------
module vsl_queue #(
    parameter int DW = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [DW-1:0]    push_data,
    input  logic             pop,
    output logic [DW-1:0]    head_data,
    output vsl_pkg::q_stat_t q_stat
);
    import vsl_pkg::*;

    logic [DW-1:0] mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    assign head_data    = mem_reg[rp_reg];
    assign q_stat.full  = (cnt_reg == 2'd2);
    assign q_stat.empty = (cnt_reg == 2'd0);

endmodule

@@ hw/rtl/vsl_back.sv @@
// ----------------------------------------------------------------------------
// vsl_back
// Executes queued requests: interval history and median, timeout, feedback
// fallback, direction-keeping step limits with a serial divider, output.
// ----------------------------------------------------------------------------
module vsl_back #(
    parameter int HISTORY_DEPTH = 5,
    parameter int VEL_WIDTH     = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  vsl_pkg::cfg_t                    cfg,
    input  logic [2+32+3*VEL_WIDTH-1:0]      head_data,
    input  vsl_pkg::q_stat_t                 q_stat,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [95:0]                      m_tdata,  // cmd_x, cmd_y, cmd_w
    output logic [0:0]                       m_tuser   // passed_through
);
    import vsl_pkg::*;

    localparam int W  = ((VEL_WIDTH > 18) ? VEL_WIDTH : 18) + 2;
    localparam int AW = VEL_WIDTH + 1;
    localparam int PW = AW + 16;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int IW = $clog2(HISTORY_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
    localparam logic [CW-1:0] HALF_C  = CW'(HISTORY_DEPTH / 2);
    localparam logic [IW-1:0] LAST_I  = IW'(HISTORY_DEPTH - 1);
    localparam logic signed [W-1:0] VMAX =
        {{(W-VEL_WIDTH+1){1'b0}}, {(VEL_WIDTH-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = ~VMAX;

    function automatic logic signed [VEL_WIDTH-1:0] sat_v(input logic signed [W-1:0] v);
        return VEL_WIDTH'((v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v));
    endfunction

    // head of queue
    kind_t                       h_kind;
    logic [31:0]                 h_time;
    logic signed [VEL_WIDTH-1:0] h_vel [3];

    assign h_kind = kind_t'(head_data[1:0]);
    assign h_time = head_data[33:2];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            h_vel[i] = head_data[34+VEL_WIDTH*i +: VEL_WIDTH];
    end

    state_t state_reg, state_next;

    logic signed [VEL_WIDTH-1:0] tgt_reg [3];
    logic signed [VEL_WIDTH-1:0] last_reg [3];
    logic signed [VEL_WIDTH-1:0] fb_reg [3];
    logic                        active_reg;
    logic [31:0]                 last_time_reg;
    logic [31:0]                 hist_reg [HISTORY_DEPTH];
    logic [CW-1:0]               cnt_reg;
    logic [IW-1:0]               next_reg;
    logic [31:0]                 avg_reg;
    logic [31:0]                 now_reg;
    logic signed [W-1:0]         inc_reg [3];
    logic [AW-1:0]               ainc_reg [3];
    logic [15:0]                 mx_reg [3];
    logic                        pair_reg;
    logic [PW-1:0]               p1_reg, p2_reg, rem_reg;
    logic [AW-1:0]               dsr_reg;
    logic [15:0]                 q_reg;
    logic [3:0]                  bit_reg;
    logic                        dest_w_reg;
    logic [IW-1:0]               cand_reg;
    logic [31:0]                 res_reg [3];
    logic                        res_pt_reg;
    logic                        ovalid_reg;
    logic [31:0]                 odata_reg [3];
    logic                        opt_reg;

    // per-axis steps and widened state
    logic [15:0]         acc [3];
    logic [15:0]         dec [3];
    logic signed [W-1:0] tgt_w [3];
    logic signed [W-1:0] last_w [3];
    logic signed [W-1:0] fb_w [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i]    = cfg.accel_steps[16*i +: 16];
            dec[i]    = cfg.decel_steps[16*i +: 16];
            tgt_w[i]  = W'(tgt_reg[i]);
            last_w[i] = W'(last_reg[i]);
            fb_w[i]   = W'(fb_reg[i]);
        end
    end

    logic [1:0] fbm;
    assign fbm = fb_eff(cfg.feedback_mode);

    // command history bookkeeping
    logic [CW-1:0] cnt_new;
    assign cnt_new = (cnt_reg < DEPTH_C) ? cnt_reg + 1'b1 : cnt_reg;

    // timeout on tick
    logic [31:0] el_now;
    logic [34:0] lim3, lim_t;
    logic        tmo;
    assign el_now = h_time - last_time_reg;
    assign lim3   = {2'b0, avg_reg} + {1'b0, avg_reg, 1'b0};
    assign lim_t  = (lim3 > TIMEOUT_CAP) ? TIMEOUT_CAP : lim3;
    assign tmo    = active_reg && (avg_reg != 32'd0) && ({3'b0, el_now} > lim_t);

    // feedback fallback
    logic [31:0] el_fb;
    logic [34:0] lim5;
    logic        fall;
    always_comb
    begin
        logic dev;
        el_fb = now_reg - last_time_reg;
        lim5  = {3'b0, avg_reg} + {1'b0, avg_reg, 2'b0};
        dev   = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if ((fb_w[i] < last_w[i] - $signed(W'({dec[i], 1'b0}))) ||
                (fb_w[i] > last_w[i] + $signed(W'({acc[i], 1'b0}))))
                dev = 1'b1;
        end
        fall = (fbm != FB_NONE) && active_reg && (avg_reg != 32'd0) &&
               (dev || ({3'b0, el_fb} > lim5));
    end

    // step preparation
    logic                same;
    logic signed [W-1:0] inc_c [3];
    logic [AW-1:0]       ainc_c [3];
    logic [15:0]         mx_c [3];
    always_comb
    begin
        same = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (tgt_reg[i] != last_reg[i])
                same = 1'b0;
            inc_c[i]  = tgt_w[i] - last_w[i];
            ainc_c[i] = AW'((inc_c[i] < 0) ? -inc_c[i] : inc_c[i]);
            if ((fbm == FB_ODOM) &&
                ((fb_w[i] > 0 && tgt_w[i] < 0) || (fb_w[i] < 0 && tgt_w[i] > 0)))
                mx_c[i] = dec[i];
            else if ((inc_c[i] > 0 && tgt_w[i] > 0) || (inc_c[i] < 0 && tgt_w[i] < 0))
                mx_c[i] = acc[i];
            else
                mx_c[i] = dec[i];
        end
    end

    // direction pair: a is x or y, w is angular
    logic [AW-1:0] a_inc, w_inc;
    logic [15:0]   ma;
    logic          skip_pair, cmp_lt, div_ok;
    assign a_inc     = ainc_reg[pair_reg];
    assign w_inc     = ainc_reg[2];
    assign ma        = mx_reg[pair_reg];
    assign skip_pair = (a_inc == '0) && (w_inc == '0);
    assign cmp_lt    = (p1_reg < p2_reg);
    assign div_ok    = cmp_lt ? (w_inc != '0) : (a_inc != '0);

    // divider step
    logic [PW-1:0] dshift;
    logic          dfit;
    assign dshift = PW'(dsr_reg) << bit_reg;
    assign dfit   = (rem_reg >= dshift);

    // limited command
    logic signed [W-1:0] cmd_c [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (ainc_reg[i] > AW'(mx_reg[i]))
                cmd_c[i] = (inc_reg[i] < 0) ? last_w[i] - W'(mx_reg[i])
                                            : last_w[i] + W'(mx_reg[i]);
            else
                cmd_c[i] = tgt_w[i];
        end
    end

    // median rank of the candidate
    logic [CW-1:0] rank;
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < HISTORY_DEPTH; j++)
        begin
            if ((CW'(j) < cnt_reg) &&
                ((hist_reg[j] < hist_reg[cand_reg]) ||
                 (hist_reg[j] == hist_reg[cand_reg] && IW'(j) < cand_reg)))
                rank = rank + 1'b1;
        end
    end

    logic out_free;
    assign out_free = !ovalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    unique case (h_kind)
                        K_CMD:   state_next = (cnt_new > HALF_C) ? S_MED : S_IDLE;
                        K_FB:    state_next = S_IDLE;
                        default: state_next = (!cfg.smoother_on && active_reg) ? S_OUT : S_FB;
                    endcase
                end
            end
            S_FB:    state_next = S_PREP;
            S_PREP:  state_next = !same ? S_MUL1 : (active_reg ? S_OUT : S_IDLE);
            S_MUL1:  state_next = !skip_pair ? S_MUL2 : (pair_reg ? S_APPLY : S_MUL1);
            S_MUL2:  state_next = S_CMP;
            S_CMP:   state_next = div_ok ? S_DIV : (pair_reg ? S_APPLY : S_MUL1);
            S_DIV:   state_next = (bit_reg != 4'd0) ? S_DIV : (pair_reg ? S_APPLY : S_MUL1);
            S_APPLY: state_next = S_OUT;
            S_MED:   state_next = (rank == (cnt_reg >> 1)) ? S_IDLE : S_MED;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic out_load;
    always_comb
    begin
        pop      = (state_reg == S_IDLE) && !q_stat.empty;
        out_load = (state_reg == S_OUT) && out_free;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            last_time_reg <= '0;
            cnt_reg       <= '0;
            next_reg      <= '0;
            avg_reg       <= '0;
            ovalid_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                tgt_reg[i]  <= '0;
                last_reg[i] <= '0;
                fb_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop && h_kind == K_CMD)
                    begin
                        next_reg      <= (next_reg == LAST_I) ? '0 : next_reg + 1'b1;
                        cnt_reg       <= cnt_new;
                        last_time_reg <= h_time;
                        active_reg    <= 1'b1;
                        if (cnt_new <= HALF_C)
                            avg_reg <= DEFAULT_INTERVAL;
                        for (int i = 0; i < 3; i++)
                            tgt_reg[i] <= h_vel[i];
                    end
                    else if (pop && h_kind == K_FB)
                    begin
                        for (int i = 0; i < 3; i++)
                            fb_reg[i] <= h_vel[i];
                    end
                    else if (pop && (cfg.smoother_on || !active_reg) && tmo)
                    begin
                        active_reg <= 1'b0;
                        for (int i = 0; i < 3; i++)
                            tgt_reg[i] <= '0;
                    end
                end
                S_FB:
                begin
                    if (fall)
                    begin
                        for (int i = 0; i < 3; i++)
                            last_reg[i] <= fb_reg[i];
                    end
                end
                S_APPLY:
                begin
                    for (int i = 0; i < 3; i++)
                        last_reg[i] <= sat_v(cmd_c[i]);
                end
                S_MED:
                begin
                    if (rank == (cnt_reg >> 1))
                        avg_reg <= hist_reg[cand_reg];
                end
                default: ;
            endcase
        end
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (pop && h_kind == K_CMD)
            hist_reg[next_reg] <= el_now;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                now_reg    <= h_time;
                cand_reg   <= '0;
                res_pt_reg <= 1'b1;
                for (int i = 0; i < 3; i++)
                    res_reg[i] <= 32'(tgt_reg[i]);
            end
            S_PREP:
            begin
                pair_reg   <= 1'b0;
                res_pt_reg <= 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    inc_reg[i]  <= inc_c[i];
                    ainc_reg[i] <= ainc_c[i];
                    mx_reg[i]   <= mx_c[i];
                    res_reg[i]  <= 32'(last_reg[i]);
                end
            end
            S_MUL1:
            begin
                p1_reg <= PW'(mx_reg[2]) * PW'(a_inc);
                if (skip_pair)
                    pair_reg <= 1'b1;
            end
            S_MUL2:
                p2_reg <= PW'(w_inc) * PW'(ma);
            S_CMP:
            begin
                rem_reg    <= cmp_lt ? p1_reg : p2_reg;
                dsr_reg    <= cmp_lt ? w_inc : a_inc;
                dest_w_reg <= !cmp_lt;
                q_reg      <= '0;
                bit_reg    <= 4'd15;
                if (!div_ok)
                    pair_reg <= 1'b1;
            end
            S_DIV:
            begin
                if (dfit)
                    rem_reg <= rem_reg - dshift;
                q_reg[bit_reg] <= dfit;
                bit_reg        <= bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                begin
                    if (dest_w_reg)
                        mx_reg[2] <= {q_reg[15:1], dfit};
                    else
                        mx_reg[pair_reg] <= {q_reg[15:1], dfit};
                    pair_reg <= 1'b1;
                end
            end
            S_APPLY:
            begin
                for (int i = 0; i < 3; i++)
                    res_reg[i] <= 32'(sat_v(cmd_c[i]));
            end
            S_MED:
                cand_reg <= cand_reg + 1'b1;
            default: ;
        endcase
        if (out_load)
        begin
            opt_reg <= res_pt_reg;
            for (int i = 0; i < 3; i++)
                odata_reg[i] <= res_reg[i];
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {odata_reg[2], odata_reg[1], odata_reg[0]};
    assign m_tuser  = opt_reg;

endmodule

@@ hw/rtl/velocity_slew_limiter_top.sv @@
// Back end: a command or feedback request is handled in S_IDLE; a command also runs
// the S_MED median search once the interval history is over half full.
// A tick may run the step states, where two serial 16-step divisions dominate.
// Requests are taken one at a time from a two-entry queue; results leave via a register.
// Reset (rst_n, async, low) clears control state and config, not history or datapath; no clearing pass is needed.
// ----------------------------------------------------------------------------
// velocity_slew_limiter_top
// Acceleration limited velocity smoother with stream ports and a config port.
// ----------------------------------------------------------------------------
module velocity_slew_limiter_top #(
    parameter int HISTORY_DEPTH = 5,
    parameter int VEL_WIDTH     = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // time_us, vel_x, vel_y, vel_w
    input  logic [1:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // cmd_x, cmd_y, cmd_w
    output logic [0:0]   m_tuser,   // passed_through
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [59:0]  cfg_data
);
    import vsl_pkg::*;

    localparam int DW = 2 + 32 + 3 * VEL_WIDTH;

    cfg_t          cfg_reg;
    q_stat_t       q_stat;
    logic          q_push, q_pop;
    logic [DW-1:0] push_data, head_data;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoother_on   <= 1'b1;
            cfg_reg.feedback_mode <= FB_NONE;
            cfg_reg.speed_limits  <= '0;
            cfg_reg.accel_steps   <= '0;
            cfg_reg.decel_steps   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SMOOTHER_ON:   cfg_reg.smoother_on   <= cfg_data[0];
                REG_FEEDBACK_MODE: cfg_reg.feedback_mode <= cfg_data[1:0];
                REG_SPEED_LIMITS:  cfg_reg.speed_limits  <= cfg_data;
                REG_ACCEL_STEPS:   cfg_reg.accel_steps   <= cfg_data[47:0];
                REG_DECEL_STEPS:   cfg_reg.decel_steps   <= cfg_data[47:0];
                default: ;
            endcase
        end
    end

    vsl_front #(.VEL_WIDTH(VEL_WIDTH)) u_front (
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_data (push_data)
    );

    vsl_queue #(.DW(DW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .head_data (head_data),
        .q_stat    (q_stat)
    );

    vsl_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .VEL_WIDTH(VEL_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head_data (head_data),
        .q_stat    (q_stat),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

`ifndef SYNTHESIS
    // no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("push into full queue");
    // no pop from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");
    // pass-through results only come with smoothing off
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> !cfg_reg.smoother_on)
        else $error("pass-through with smoothing on");
`endif

endmodule
